>>> design/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

   localparam int CENTER_W    = 12;
   localparam int RADIUS_W    = 11;
   localparam int PIXEL_W     = 14;
   localparam int OCTANT_W    = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OCTANT_W-1:0] FIRST_OCTANT = 3'd0;
   localparam logic [OCTANT_W-1:0] LAST_OCTANT  = 3'd7;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } mcr_op_type;

   // one step word handed from front to back
   typedef struct packed {
      logic               plot;
      logic               done;
      logic [PIXEL_W-1:0] cx;
      logic [PIXEL_W-1:0] cy;
      logic [PIXEL_W-1:0] major;
      logic [PIXEL_W-1:0] minor;
   } mcr_entry_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] dx;
      logic [PIXEL_W-1:0] dy;
   } mcr_offset_type;

   // octant mirror of the current point
   function automatic mcr_offset_type octant_offset(input logic [OCTANT_W-1:0] oct,
                                                    input logic [PIXEL_W-1:0]  major,
                                                    input logic [PIXEL_W-1:0]  minor);
      mcr_offset_type off;
      unique case (oct)
         3'd0: begin off.dx =  major; off.dy =  minor; end
         3'd1: begin off.dx =  minor; off.dy =  major; end
         3'd2: begin off.dx = -minor; off.dy =  major; end
         3'd3: begin off.dx = -major; off.dy =  minor; end
         3'd4: begin off.dx = -major; off.dy = -minor; end
         3'd5: begin off.dx = -minor; off.dy = -major; end
         3'd6: begin off.dx =  minor; off.dy = -major; end
         default: begin off.dx =  major; off.dy = -minor; end
      endcase
      return off;
   endfunction

endpackage

>>> design/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr_req_if / mcr_rsp_if
// Valid/ready channels for the rasterizer requests and pixel responses.
// ----------------------------------------------------------------------------
interface mcr_req_if import mcr_pkg::*; ();
   logic                valid;
   logic                ready;
   mcr_op_type          op;
   logic [CENTER_W-1:0] center_x;
   logic [CENTER_W-1:0] center_y;
   logic [RADIUS_W-1:0] radius;

   modport source (output valid, op, center_x, center_y, radius, input ready);
   modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

interface mcr_rsp_if import mcr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PIXEL_W-1:0] pixel_x;
   logic signed [PIXEL_W-1:0] pixel_y;
   logic                      pixel_valid;
   logic                      last_of_step;
   logic                      circle_done;

   modport source (output valid, pixel_x, pixel_y, pixel_valid, last_of_step, circle_done,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_of_step, circle_done,
                   output ready);
endinterface

>>> design/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle generator: start words load a center and radius; step words
// return the eight mirrored pixels of the current point, or one invalid pixel when idle.
// ----------------------------------------------------------------------------
// A start word returns nothing. A step word returns eight pixels, one per
// cycle while the output is not stalled, through the single pixel output
// port; a step with no circle running returns one invalid pixel. The front
// end does the error update in the cycle a word is accepted and parks the
// step in a two-word queue, so new requests keep flowing while the back end
// drains earlier steps, until the queue fills. The first pixel of a step
// passes through the queue entry and then the pixel output register.
module midpoint_circle_rasterizer import mcr_pkg::*; #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic      clock,
   input  logic      reset,
   mcr_req_if.sink   req_if,
   mcr_rsp_if.source rsp_if
);

   logic          push_valid, push_ready;
   logic          pop_valid, pop_ready;
   mcr_entry_type push_data, pop_data;

   mcr_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_if)
   );

   // every accepted step lands in the queue, nothing else does
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) == (req_if.valid && req_if.ready && req_if.op == OP_STEP))
      else $error("queue push does not match accepted step");

   // an idle step word ends on its single pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.pixel_valid) |-> (rsp_if.last_of_step && rsp_if.circle_done))
      else $error("invalid pixel not marked last and done");

   // done only on the final pixel of a step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.circle_done) |-> rsp_if.last_of_step)
      else $error("circle done before end of step");

   // a queue word is released only together with its final pixel
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (rsp_if.valid && rsp_if.last_of_step))
      else $error("queue word released without its last pixel");

endmodule

>>> design/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Accepts requests, holds the circle state and runs the midpoint update,
// pushing one word per step into the queue.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic          clock,
   input  logic          reset,
   mcr_req_if.sink       req,
   output logic          push_valid,
   input  logic          push_ready,
   output mcr_entry_type push_data
);

   localparam int OFF_W = RADIUS_BITS + 1;
   localparam int ERR_W = RADIUS_BITS + 3;
   localparam logic signed [OFF_W-1:0] OFF_ONE  = OFF_W'(1);
   localparam logic signed [ERR_W-1:0] ERR_ONE  = ERR_W'(1);
   localparam logic signed [ERR_W-1:0] ERR_ZERO = '0;

   logic                    active_ff, active_in;
   logic [COORD_BITS-1:0]   cx_ff, cx_in;
   logic [COORD_BITS-1:0]   cy_ff, cy_in;
   logic signed [OFF_W-1:0] major_ff, major_in;
   logic signed [OFF_W-1:0] minor_ff, minor_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   logic signed [OFF_W-1:0] minor_mid, major_nxt;
   logic signed [ERR_W-1:0] err_mid, err_nxt;
   logic                    done_nxt;
   logic                    accept;

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign push_valid = req.valid && (req.op == OP_STEP);

   // midpoint update
   always_comb begin
      minor_mid = minor_ff;
      err_mid   = err_ff;
      if (err_ff <= ERR_ZERO) begin
         minor_mid = minor_ff + OFF_ONE;
         err_mid   = err_ff + (ERR_W'(minor_mid) <<< 1) + ERR_ONE;
      end
      major_nxt = major_ff;
      err_nxt   = err_mid;
      if (err_mid > ERR_ZERO) begin
         major_nxt = major_ff - OFF_ONE;
         err_nxt   = err_mid - (ERR_W'(major_nxt) <<< 1) - ERR_ONE;
      end
      done_nxt = major_nxt < minor_mid;
   end

   always_comb begin
      push_data.plot  = active_ff;
      push_data.done  = active_ff ? done_nxt : 1'b1;
      push_data.cx    = PIXEL_W'(cx_ff);
      push_data.cy    = PIXEL_W'(cy_ff);
      push_data.major = PIXEL_W'(major_ff);
      push_data.minor = PIXEL_W'(minor_ff);
   end

   always_comb begin
      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      err_in    = err_ff;
      if (accept) begin
         if (req.op == OP_START) begin
            active_in = 1'b1;
            cx_in     = COORD_BITS'(req.center_x);
            cy_in     = COORD_BITS'(req.center_y);
            major_in  = signed'({1'b0, RADIUS_BITS'(req.radius)});
            minor_in  = '0;
            err_in    = '0;
         end else if (active_ff) begin
            active_in = !done_nxt;
            major_in  = major_nxt;
            minor_in  = minor_mid;
            err_in    = err_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      err_ff   <= err_in;
   end

endmodule

>>> design/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// Short first-in first-out buffer of step words between front and back.
// ----------------------------------------------------------------------------
module mcr_queue import mcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  mcr_entry_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output mcr_entry_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   mcr_entry_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Walks the eight octants of each step word and drives the pixel output
// register, one pixel per cycle while the output is not stalled by rsp.ready.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  mcr_entry_type pop_data,
   mcr_rsp_if.source     rsp
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PIXEL_W-1:0] pixel_x_ff, pixel_x_in;
   logic signed [PIXEL_W-1:0] pixel_y_ff, pixel_y_in;
   logic                      pixel_valid_ff, pixel_valid_in;
   logic                      last_ff, last_in;
   logic                      done_ff, done_in;
   logic [OCTANT_W-1:0]       oct_ff, oct_in;

   logic                      load;
   logic                      word_end;
   mcr_offset_type            off;

   assign load      = !rsp_valid_ff || rsp.ready;
   assign word_end  = !pop_data.plot || (oct_ff == LAST_OCTANT);
   assign pop_ready = load && word_end;
   assign off       = octant_offset(oct_ff, pop_data.major, pop_data.minor);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_x      = pixel_x_ff;
   assign rsp.pixel_y      = pixel_y_ff;
   assign rsp.pixel_valid  = pixel_valid_ff;
   assign rsp.last_of_step = last_ff;
   assign rsp.circle_done  = done_ff;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      pixel_valid_in = pixel_valid_ff;
      last_in        = last_ff;
      done_in        = done_ff;
      oct_in         = oct_ff;
      if (load) begin
         rsp_valid_in = pop_valid;
         if (pop_valid) begin
            if (pop_data.plot) begin
               pixel_x_in     = signed'(pop_data.cx + off.dx);
               pixel_y_in     = signed'(pop_data.cy + off.dy);
               pixel_valid_in = 1'b1;
               last_in        = word_end;
               done_in        = word_end && pop_data.done;
            end else begin
               // step with no circle running
               pixel_x_in     = '0;
               pixel_y_in     = '0;
               pixel_valid_in = 1'b0;
               last_in        = 1'b1;
               done_in        = 1'b1;
            end
            oct_in = word_end ? FIRST_OCTANT : oct_ff + OCTANT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         oct_ff       <= FIRST_OCTANT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         oct_ff       <= oct_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      pixel_valid_ff <= pixel_valid_in;
      last_ff        <= last_in;
      done_ff        <= done_in;
   end

endmodule
